[src/cpu_address_window_decoder_assert.svh]
// assertion macros for the cpu address window decoder
// expects clk and rst_n to be visible where a macro is used
`ifndef CPU_ADDRESS_WINDOW_DECODER_ASSERT_SVH
`define CPU_ADDRESS_WINDOW_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define CAWD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked at every edge, reset included
`define CAWD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CAWD_ASSERT(label, prop, msg)
`define CAWD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[src/cawd_pkg.sv]
// shared types, constants and window match functions for the address decoder
// no dependencies
package cawd_pkg;

    localparam int NUM_WINDOWS = 8;
    localparam int REG_IDX_W   = 3;
    localparam int PADDR_W     = REG_IDX_W + 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_MAIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MODULE_1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MODULE_2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_MODULE_3 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MODULE_4 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PCI_MEM1 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PCI_MEM2 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_PCI_IO   = 3'd7;

    // hit codes
    localparam logic [3:0] HIT_NONE     = 4'd0;
    localparam logic [3:0] HIT_MAIN     = 4'd1;
    localparam logic [3:0] HIT_MODULE_1 = 4'd2;
    localparam logic [3:0] HIT_MODULE_2 = 4'd3;
    localparam logic [3:0] HIT_MODULE_3 = 4'd4;
    localparam logic [3:0] HIT_MODULE_4 = 4'd5;
    localparam logic [3:0] HIT_PCI_MEM1 = 4'd6;
    localparam logic [3:0] HIT_PCI_MEM2 = 4'd7;
    localparam logic [3:0] HIT_PCI_IO   = 4'd8;

    localparam logic [31:0] MAIN_BASE_MASK   = 32'h0fc0_0000;
    localparam logic [31:0] MODULE_BASE_MASK = 32'h0fe0_0000;
    localparam logic [31:0] PCI_START_MASK   = 32'hff00_0000;
    localparam logic [31:0] PCI_TOP_BIT      = 32'h8000_0000;
    localparam logic [31:0] DWORD_MASK       = ~32'd3;
    localparam int          MEM_ENABLE_BIT   = 3;
    localparam int          PCI_ENABLE_BIT   = 12;
    localparam int          SIZE_W           = 27;
    localparam logic [SIZE_W-1:0] MAIN_SIZE0   = SIZE_W'(1 << 22);
    localparam logic [SIZE_W-1:0] MODULE_SIZE0 = SIZE_W'(1 << 21);

    typedef logic [NUM_WINDOWS-1:0][31:0] window_regs_t;

    typedef struct packed {
        logic [3:0]  window_hit;
        logic [31:0] local_address;
    } decode_res_t;

    // main window size: 4 MiB doubled per zero bit in 14..15 up to the first one
    function automatic logic [SIZE_W-1:0] main_size(input logic [31:0] r);
        logic [SIZE_W-1:0] size;
        if (r[14])
            size = MAIN_SIZE0;
        else if (r[15])
            size = MAIN_SIZE0 << 1;
        else
            size = MAIN_SIZE0 << 2;
        return size;
    endfunction

    // module window size: 2 MiB doubled per zero bit in 13..17 up to the first one
    function automatic logic [SIZE_W-1:0] module_size(input logic [31:0] r);
        logic [SIZE_W-1:0] size;
        logic              stop;
        size = MODULE_SIZE0;
        stop = 1'b0;
        for (int b = 13; b <= 17; b++)
        begin
            if (!stop)
            begin
                if (r[b])
                    stop = 1'b1;
                else
                    size = size << 1;
            end
        end
        return size;
    endfunction

    function automatic logic mem_in_window(input logic [31:0] addr, input logic [31:0] base,
                                           input logic [SIZE_W-1:0] size);
        logic [32:0] diff;
        diff = {1'b0, addr} - {1'b0, base};
        return !diff[32] && (diff[31:0] < {{(32-SIZE_W){1'b0}}, size});
    endfunction

    function automatic logic pci_in_window(input logic [31:0] addr, input logic [31:0] r);
        logic [31:0] start;
        logic [31:0] stop;
        start = r & PCI_START_MASK;
        stop  = start | ~(PCI_TOP_BIT | ({25'b0, r[19:13]} << 24));
        return r[PCI_ENABLE_BIT] && (addr >= start) && (addr <= stop);
    endfunction

    function automatic logic [31:0] pci_local(input logic [31:0] addr, input logic [31:0] r);
        return {r[7:0], 24'b0} | ((addr - (r & PCI_START_MASK)) & DWORD_MASK);
    endfunction

endpackage

[src/cawd_if.sv]
// request and result channel interfaces for the address decoder
// no dependencies
interface cawd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] cpu_address;

    modport source (output valid, output cpu_address, input ready);
    modport sink   (input valid, input cpu_address, output ready);
endinterface

interface cawd_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  window_hit;
    logic [31:0] local_address;

    modport source (output valid, output window_hit, output local_address, input ready);
    modport sink   (input valid, input window_hit, input local_address, output ready);
endinterface

[src/cawd_regs.sv]
// window register file behind an apb-style write/read port
// depends on cawd_pkg
module cawd_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cawd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output cawd_pkg::window_regs_t        windows
);
    import cawd_pkg::*;

    window_regs_t            windows_reg;
    logic                    wr_en;
    logic [REG_IDX_W-1:0]    idx;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            windows_reg <= '0;
        else if (wr_en)
            windows_reg[idx] <= pwdata;
    end

    assign prdata  = windows_reg[idx];
    assign windows = windows_reg;
endmodule

[src/cawd_decode.sv]
// window match and priority select for one address
// depends on cawd_pkg
module cawd_decode (
    input  logic [31:0]              addr,
    input  cawd_pkg::window_regs_t   windows,
    output cawd_pkg::decode_res_t    res
);
    import cawd_pkg::*;

    logic [31:0] r_main;
    logic [31:0] r_mod1;
    logic [31:0] r_mod2;
    logic [31:0] r_mod3;
    logic [31:0] r_mod4;
    logic [31:0] r_pci1;
    logic [31:0] r_pci2;
    logic [31:0] r_pcio;

    assign r_main = windows[REG_MAIN];
    assign r_mod1 = windows[REG_MODULE_1];
    assign r_mod2 = windows[REG_MODULE_2];
    assign r_mod3 = windows[REG_MODULE_3];
    assign r_mod4 = windows[REG_MODULE_4];
    assign r_pci1 = windows[REG_PCI_MEM1];
    assign r_pci2 = windows[REG_PCI_MEM2];
    assign r_pcio = windows[REG_PCI_IO];

    // higher-indexed windows take priority on overlap (PCI I/O first, main memory last)
    always_comb
    begin
        res = '{window_hit: HIT_NONE, local_address: 32'd0};
        if (pci_in_window(addr, r_pcio))
            res = '{window_hit: HIT_PCI_IO, local_address: pci_local(addr, r_pcio)};
        else if (pci_in_window(addr, r_pci2))
            res = '{window_hit: HIT_PCI_MEM2, local_address: pci_local(addr, r_pci2)};
        else if (pci_in_window(addr, r_pci1))
            res = '{window_hit: HIT_PCI_MEM1, local_address: pci_local(addr, r_pci1)};
        else if (r_mod4[MEM_ENABLE_BIT]
                 && mem_in_window(addr, r_mod4 & MODULE_BASE_MASK, module_size(r_mod4)))
            res = '{window_hit: HIT_MODULE_4,
                    local_address: (addr - (r_mod4 & MODULE_BASE_MASK)) & DWORD_MASK};
        else if (r_mod3[MEM_ENABLE_BIT]
                 && mem_in_window(addr, r_mod3 & MODULE_BASE_MASK, module_size(r_mod3)))
            res = '{window_hit: HIT_MODULE_3,
                    local_address: (addr - (r_mod3 & MODULE_BASE_MASK)) & DWORD_MASK};
        else if (r_mod2[MEM_ENABLE_BIT]
                 && mem_in_window(addr, r_mod2 & MODULE_BASE_MASK, module_size(r_mod2)))
            res = '{window_hit: HIT_MODULE_2,
                    local_address: (addr - (r_mod2 & MODULE_BASE_MASK)) & DWORD_MASK};
        else if (r_mod1[MEM_ENABLE_BIT]
                 && mem_in_window(addr, r_mod1 & MODULE_BASE_MASK, module_size(r_mod1)))
            res = '{window_hit: HIT_MODULE_1,
                    local_address: (addr - (r_mod1 & MODULE_BASE_MASK)) & DWORD_MASK};
        else if (r_main[MEM_ENABLE_BIT]
                 && mem_in_window(addr, r_main & MAIN_BASE_MASK, main_size(r_main)))
            res = '{window_hit: HIT_MAIN,
                    local_address: (addr - (r_main & MAIN_BASE_MASK)) & DWORD_MASK};
    end
endmodule

[src/cpu_address_window_decoder.sv]
// Decodes one processor byte address per clock against eight window registers
// (main memory, four memory modules, two PCI memory windows, one PCI I/O window)
// and returns the hit window code with a dword-aligned local address. A request
// is registered on acceptance and decoded into the result register; a new
// request is taken every cycle, the only limit on throughput being the result
// side taking results. The user must write the window registers through the APB
// port only while no request is in flight; the block does not enforce this.
// depends on cawd_pkg, cawd_if, cawd_regs, cawd_decode and the assertion header
`include "cpu_address_window_decoder_assert.svh"

module cpu_address_window_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    cawd_in_if.sink                       in,
    cawd_out_if.source                    out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cawd_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cawd_pkg::*;

    window_regs_t  windows;
    decode_res_t   dec_res;
    decode_res_t   res_reg;
    logic [31:0]   addr_reg;
    logic          s1_valid_reg;
    logic          out_valid_reg;
    logic          out_free;
    logic          s1_advance;
    logic          in_take;

    cawd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .windows (windows)
    );

    cawd_decode u_decode (
        .addr    (addr_reg),
        .windows (windows),
        .res     (dec_res)
    );

    assign out_free   = !out_valid_reg || out.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in.ready   = !s1_valid_reg || out_free;
    assign in_take    = in.valid && in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in.ready)
                s1_valid_reg <= in.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            addr_reg <= in.cpu_address;
        if (s1_advance)
            res_reg <= dec_res;
    end

    assign out.valid         = out_valid_reg;
    assign out.window_hit    = res_reg.window_hit;
    assign out.local_address = res_reg.local_address;

    `CAWD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!s1_valid_reg && !out_valid_reg), "pipeline not empty in reset")
    `CAWD_ASSERT(a_take_loads_stage, in_take |=> s1_valid_reg, "accepted request not in input stage")
    `CAWD_ASSERT(a_stage_holds, (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(addr_reg)), "input stage lost while stalled")
    `CAWD_ASSERT(a_miss_zero, (out_valid_reg && res_reg.window_hit == HIT_NONE) |-> res_reg.local_address == 32'd0, "miss with nonzero local address")
    `CAWD_ASSERT(a_hit_range, out_valid_reg |-> res_reg.window_hit <= HIT_PCI_IO, "hit code out of range")
endmodule
